// ===== design/wsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int CMD_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 2;

	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
	localparam int         KEY_BYTES      = 4;

	typedef enum logic [2:0] {
		PH_HDR0  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_EXTHI = 3'd2,
		PH_EXTLO = 3'd3,
		PH_KEY   = 3'd4,
		PH_DATA  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		CMD_KEY   = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_EMPTY = 2'd2,
		CMD_ERROR = 2'd3
	} cmd_kind_t;

	// work item from the parser to the execution side
	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic [1:0] idx;
		logic [3:0] opcode;
		logic       last;
		logic       masked;
	} cmd_t;

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] opcode;
		logic       last;
		logic       empty;
		logic       err;
	} res_t;

endpackage

// ===== design/websocket_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Receive-side frame deframer: one stream byte in, unmasked payload beats out.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | push / full        | in_byte
//  result   | empty / pop        | out_byte, frame_opcode, frame_last,
//           |                    | frame_empty, length_error
//
// One byte per cycle sustained while full stays low; the parser steps once per accepted byte.
// A result is registered in the command queue, then in the result queue.
// full follows the command queue only; a stalled result side backs up the
// result queue, then the command queue, then the input.
// Reset clears the parser and queue pointers; the mask key needs no reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top import wsd_pkg::*; #(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic [3:0] frame_opcode,
	output logic       frame_last,
	output logic       frame_empty,
	output logic       length_error
);

	logic accept;
	logic cmd_push, cmd_pop, cmd_empty;
	logic res_push, res_full;
	cmd_t cmd_in, cmd_out;
	res_t res_in, res_out;

	assign accept = push && !full;

	wsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	wsd_fifo #(
		.DEPTH (CMD_DEPTH),
		.WIDTH ($bits(cmd_t))
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	wsd_back u_back (
		.clk       (clk),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	wsd_fifo #(
		.DEPTH (OUT_DEPTH),
		.WIDTH ($bits(res_t))
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign out_byte     = res_out.data;
	assign frame_opcode = res_out.opcode;
	assign frame_last   = res_out.last;
	assign frame_empty  = res_out.empty;
	assign length_error = res_out.err;

	a_cmd_from_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> accept)
		else $error("command pushed without an input beat");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty && (cmd_out.kind == CMD_KEY || !res_full))
		else $error("command retired without room for its result");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && length_error) |-> (frame_last && !frame_empty && out_byte == 8'd0))
		else $error("malformed length error result");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_empty) |-> (frame_last && !length_error && out_byte == 8'd0))
		else $error("malformed empty frame result");

endmodule

// ===== design/wsd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module wsd_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == DEPTH_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/wsd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_front
// Header parser: walks the frame header and turns key bytes, payload bytes,
// empty frames and length rejects into commands for the execution side.
// ----------------------------------------------------------------------------
module wsd_front import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	output logic       cmd_push,
	output cmd_t       cmd
);

	phase_t      phase_q, phase_n;
	logic [3:0]  opcode_q, opcode_n;
	logic        mask_q, mask_n;
	logic [15:0] len_q, len_n;
	logic [15:0] cnt_q, cnt_n;
	logic [15:0] cnt_inc;
	logic        len_done, key_done, gen;

	assign cnt_inc = cnt_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= '0;
			mask_q   <= 1'b0;
			len_q    <= '0;
			cnt_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_n;
			opcode_q <= opcode_n;
			mask_q   <= mask_n;
			len_q    <= len_n;
			cnt_q    <= cnt_n;
		end
	end

	always_comb begin
		phase_n    = phase_q;
		opcode_n   = opcode_q;
		mask_n     = mask_q;
		len_n      = len_q;
		cnt_n      = cnt_q;
		len_done   = 1'b0;
		key_done   = 1'b0;
		gen        = 1'b0;
		cmd.kind   = CMD_DATA;
		cmd.data   = in_byte;
		cmd.idx    = cnt_q[1:0];
		cmd.opcode = opcode_q;
		cmd.last   = 1'b1;
		cmd.masked = mask_q;
		case (phase_q)
			PH_HDR1: begin
				mask_n = in_byte[7];
				if (in_byte[6:0] == LEN_CODE_EXT64) begin
					phase_n  = PH_HDR0;
					gen      = 1'b1;
					cmd.kind = CMD_ERROR;
				end else if (in_byte[6:0] == LEN_CODE_EXT16) begin
					phase_n = PH_EXTHI;
				end else begin
					len_n    = {9'd0, in_byte[6:0]};
					len_done = 1'b1;
				end
			end
			PH_EXTHI: begin
				len_n   = {in_byte, 8'd0};
				phase_n = PH_EXTLO;
			end
			PH_EXTLO: begin
				len_n    = {len_q[15:8], in_byte};
				len_done = 1'b1;
			end
			PH_KEY: begin
				gen      = 1'b1;
				cmd.kind = CMD_KEY;
				if (cnt_q[1:0] == 2'(KEY_BYTES - 1)) begin
					key_done = 1'b1;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			PH_DATA: begin
				gen = 1'b1;
				if (cnt_inc >= len_q) begin
					cmd.last = 1'b1;
					cnt_n    = '0;
					phase_n  = PH_HDR0;
				end else begin
					cmd.last = 1'b0;
					cnt_n    = cnt_inc;
				end
			end
			default: begin
				opcode_n = in_byte[3:0];
				phase_n  = PH_HDR1;
			end
		endcase

		// length or key known: key bytes next, straight to payload, or an empty-frame command
		if (len_done || key_done) begin
			cnt_n = '0;
			if (len_done && mask_n) begin
				phase_n = PH_KEY;
			end else if (len_n == 16'd0) begin
				phase_n  = PH_HDR0;
				gen      = 1'b1;
				cmd.kind = CMD_EMPTY;
			end else begin
				phase_n = PH_DATA;
			end
		end
	end

	assign cmd_push = accept && gen;

endmodule

// ===== design/wsd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_back
// Executes parser commands: holds the mask key, unmasks payload beats and
// forms result beats.
// ----------------------------------------------------------------------------
module wsd_back import wsd_pkg::*; (
	input  logic clk,
	input  cmd_t cmd,
	input  logic cmd_empty,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res
);

	logic [7:0] key_q [KEY_BYTES];
	logic       is_key;

	assign is_key  = (cmd.kind == CMD_KEY);
	// key writes retire without needing room in the result queue
	assign cmd_pop  = !cmd_empty && (is_key || !res_full);
	assign res_push = cmd_pop && !is_key;

	always_ff @(posedge clk) begin
		if (cmd_pop && is_key) begin
			key_q[cmd.idx] <= cmd.data;
		end
	end

	always_comb begin
		res.opcode = cmd.opcode;
		res.last   = cmd.last;
		res.empty  = (cmd.kind == CMD_EMPTY);
		res.err    = (cmd.kind == CMD_ERROR);
		if (cmd.kind == CMD_DATA) begin
			res.data = cmd.masked ? (cmd.data ^ key_q[cmd.idx]) : cmd.data;
		end else begin
			res.data = 8'd0;
		end
	end

endmodule

// ===== tb/deframe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframe_checker
// Watches both queue ports of the frame deframer, tracks the receive parser
// byte by byte and compares every result beat with the predicted one.
// ----------------------------------------------------------------------------
module deframe_checker import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] in_byte,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] out_byte,
	input  logic [3:0] frame_opcode,
	input  logic       frame_last,
	input  logic       frame_empty,
	input  logic       length_error,
	input  logic       run_done,
	output int         fail_count,
	output int         outstanding,
	output int         beats_checked,
	output logic       at_header
);

	phase_t      ph;
	logic [3:0]  op;
	logic        masked;
	logic [15:0] plen;
	logic [15:0] cnt;
	logic [7:0]  key [KEY_BYTES];

	res_t        pending_beats [$];
	res_t        want;
	res_t        fresh;
	bit          produced;
	bit          drain_checked;

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("%0t deframe: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp_val);
		fail_count++;
	endtask

	function automatic res_t beat(input logic [7:0] data, input logic last,
			input logic is_empty, input logic err);
		res_t r;
		r.data   = data;
		r.opcode = op;
		r.last   = last;
		r.empty  = is_empty;
		r.err    = err;
		return r;
	endfunction

	// length known; keys still to come when the frame is masked
	task automatic length_known(input bit keys_done, output bit got, output res_t r);
		got = 0;
		r   = '0;
		cnt = '0;
		if (masked && !keys_done) begin
			ph = PH_KEY;
		end else if (plen == 16'd0) begin
			ph  = PH_HDR0;
			got = 1;
			r   = beat(8'h00, 1'b1, 1'b1, 1'b0);
		end else begin
			ph = PH_DATA;
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b, output bit got, output res_t r);
		logic [6:0] code;
		logic [7:0] d;
		logic       last;
		got = 0;
		r   = '0;
		case (ph)
			PH_HDR1: begin
				masked = b[7];
				code   = b[6:0];
				if (code == LEN_CODE_EXT64) begin
					ph  = PH_HDR0;
					got = 1;
					r   = beat(8'h00, 1'b1, 1'b0, 1'b1);
				end else if (code == LEN_CODE_EXT16) begin
					ph = PH_EXTHI;
				end else begin
					plen = {9'd0, code};
					length_known(1'b0, got, r);
				end
			end
			PH_EXTHI: begin
				plen = {b, 8'h00};
				ph   = PH_EXTLO;
			end
			PH_EXTLO: begin
				plen = plen | {8'h00, b};
				length_known(1'b0, got, r);
			end
			PH_KEY: begin
				key[cnt[1:0]] = b;
				cnt = cnt + 16'd1;
				if (cnt >= KEY_BYTES)
					length_known(1'b1, got, r);
			end
			PH_DATA: begin
				d    = masked ? (b ^ key[cnt[1:0]]) : b;
				cnt  = cnt + 16'd1;
				last = (cnt >= plen);
				if (last) begin
					cnt = '0;
					ph  = PH_HDR0;
				end
				got = 1;
				r   = beat(d, last, 1'b0, 1'b0);
			end
			default: begin
				// header flags in the top nibble are dropped
				op = b[3:0];
				ph = PH_HDR1;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph            = PH_HDR0;
			op            = '0;
			masked        = 1'b0;
			plen          = '0;
			cnt           = '0;
			drain_checked = 0;
			pending_beats.delete();
			outstanding   = 0;
			at_header     = 1'b1;
		end else begin
			if (push && !full) begin
				deframe_byte(in_byte, produced, fresh);
				if (produced)
					pending_beats.push_back(fresh);
			end
			if (pop && !empty) begin
				if (pending_beats.size() == 0) begin
					report_mismatch("unexpected beat, out_byte", out_byte, 0);
				end else begin
					want = pending_beats.pop_front();
					beats_checked++;
					if (out_byte !== want.data)
						report_mismatch("out_byte", out_byte, want.data);
					if (frame_opcode !== want.opcode)
						report_mismatch("frame_opcode", frame_opcode, want.opcode);
					if (frame_last !== want.last)
						report_mismatch("frame_last", frame_last, want.last);
					if (frame_empty !== want.empty)
						report_mismatch("frame_empty", frame_empty, want.empty);
					if (length_error !== want.err)
						report_mismatch("length_error", length_error, want.err);
				end
			end
			if (run_done && !drain_checked) begin
				drain_checked = 1;
				if (pending_beats.size() != 0)
					report_mismatch("beats never delivered", 0, pending_beats.size());
			end
			outstanding = pending_beats.size();
			at_header   = (ph == PH_HDR0);
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the deframer a byte stream of directed frames, then random frames
// mixed with length rejects, noise and cut-off frames, with random gaps on
// both queue ports. The checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
	import wsd_pkg::*;

	logic       clk    = 1'b0;
	logic       arst_n = 1'b0;
	logic       push   = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       pop    = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] out_byte;
	logic [3:0] frame_opcode;
	logic       frame_last;
	logic       frame_empty;
	logic       length_error;

	logic       run_done = 1'b0;
	int         fail_count;
	int         outstanding;
	int         beats_checked;
	logic       at_header;

	int         sent_bytes;
	int         frames_sent;
	int         rejects_sent;
	int         junk_segments;
	bit         calm;
	int         stall_left;

	websocket_frame_deframer_top dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .in_byte(in_byte),
		.empty(empty), .pop(pop),
		.out_byte(out_byte), .frame_opcode(frame_opcode), .frame_last(frame_last),
		.frame_empty(frame_empty), .length_error(length_error)
	);

	deframe_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .in_byte(in_byte),
		.empty(empty), .pop(pop),
		.out_byte(out_byte), .frame_opcode(frame_opcode), .frame_last(frame_last),
		.frame_empty(frame_empty), .length_error(length_error),
		.run_done(run_done), .fail_count(fail_count), .outstanding(outstanding),
		.beats_checked(beats_checked), .at_header(at_header)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// length code 126 in noise could start a huge payload; keep resync short
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b[6:0] == LEN_CODE_EXT16)
			b[1] = 1'b0;
		return b;
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left--;
		end else begin
			pop <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int idle;
		idle = calm ? 0 : pick_gap();
		if (idle > 0) begin
			push <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		push    <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		sent_bytes++;
	endtask

	// body_cut < 0 sends the whole frame, else only that many key/payload bytes
	task automatic send_frame(input logic [7:0] hdr0, input bit mask, input logic [15:0] len,
			input bit ext, input int body_cut);
		int total;
		int body;
		total = (mask ? KEY_BYTES : 0) + len;
		body  = (body_cut < 0) ? total : body_cut;
		send_byte(hdr0);
		if (ext) begin
			send_byte({mask, LEN_CODE_EXT16});
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end else begin
			send_byte({mask, len[6:0]});
		end
		for (int i = 0; i < body; i++)
			send_byte(8'($urandom));
		frames_sent++;
	endtask

	task automatic pick_length(output logic [15:0] len, output bit ext);
		int r;
		r   = $urandom_range(0, 99);
		ext = 1'b0;
		if (r < 40)
			len = 16'($urandom_range(0, 3));
		else if (r < 70)
			len = 16'($urandom_range(4, 16));
		else if (r < 80)
			len = 16'($urandom_range(17, 125));
		else if (r < 85)
			len = 16'd125;
		else begin
			ext = 1'b1;
			r   = $urandom_range(0, 9);
			if (r < 2)
				len = 16'd0;
			else if (r < 8)
				len = 16'($urandom_range(1, 20));
			else
				len = 16'($urandom_range(126, 300));
		end
	endtask

	// idle cycle before each look so the parser state has settled
	task automatic resync();
		push <= 1'b0;
		@(posedge clk);
		while (!at_header) begin
			send_byte(noise_byte());
			push <= 1'b0;
			@(posedge clk);
		end
	endtask

	initial begin
		logic [7:0]  intro [25];
		logic [15:0] len;
		bit          ext;
		bit          mask;
		int          pick;
		int          total;

		// empty frames plain and masked, length reject, extended zero,
		// masked payload with extreme bytes, plain payload
		intro = '{8'h81, 8'h00,
			8'h8A, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44,
			8'h02, 8'hFF,
			8'h0F, 8'h7E, 8'h00, 8'h00,
			8'h7F, 8'h82, 8'h5A, 8'h00, 8'hC3, 8'h81, 8'hFF, 8'h00,
			8'h09, 8'h01, 8'hA5};

		calm = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (intro[i])
			send_byte(intro[i]);

		while (sent_bytes < 1725) begin
			calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			mask = ($urandom_range(0, 9) < 7);
			if (pick < 70) begin
				pick_length(len, ext);
				send_frame(8'($urandom), mask, len, ext, -1);
			end else if (pick < 80) begin
				send_byte(8'($urandom));
				send_byte({mask, LEN_CODE_EXT64});
				rejects_sent++;
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 6))
					send_byte(noise_byte());
				junk_segments++;
				resync();
			end else begin
				len   = 16'($urandom_range(1, 16));
				total = (mask ? KEY_BYTES : 0) + len;
				send_frame(8'($urandom), mask, len, 1'($urandom_range(0, 1)),
					int'($urandom_range(0, total - 1)));
				junk_segments++;
				resync();
			end
		end
		push <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		run_done <= 1'b1;
		repeat (2) @(posedge clk);

		$display("deframe run: %0d bytes, %0d frames, %0d length rejects, %0d noise/cut segments",
			sent_bytes, frames_sent, rejects_sent, junk_segments);
		$display("deframe run: %0d result beats compared", beats_checked);
		if (fail_count == 0)
			$display("websocket_frame_deframer_top: match");
		else
			$display("websocket_frame_deframer_top: mismatch");
		$finish;
	end

	initial begin
		#4000000;
		$display("deframe run: timed out with %0d beats outstanding", outstanding);
		$display("websocket_frame_deframer_top: mismatch");
		$finish;
	end

endmodule
